// ===== hdl/mlri_pkg.sv =====
// Package for the leaky-ReLU MLP inference block: sizes, codes, state types,
// the MAC control word and the count clamp.
// No dependencies.
`default_nettype none

package mlri_pkg;

  localparam int DATA_W      = 16;
  localparam int FRAC_W      = 12;
  localparam int COUNT_W     = 7;
  localparam int OUTCNT_W    = 5;
  localparam int OIDX_W      = 4;
  localparam int MAX_INPUTS  = 64;
  localparam int MAX_HIDDEN  = 64;
  localparam int MAX_OUTPUTS = 16;
  localparam int PARAM_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(PARAM_DEPTH);
  localparam int MAX_N       = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int BUF_AW      = $clog2(MAX_N);
  localparam int ACC_W       = 2 * DATA_W + $clog2(MAX_N) + 1;
  localparam int SLOPE_Q     = 410;
  localparam int ONE_Q       = 2 ** FRAC_W;
  localparam int RND_HALF    = 2 ** (FRAC_W - 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THREE_LAYER   = 3'd0,
    CFG_INPUT_COUNT   = 3'd1,
    CFG_FIRST_HIDDEN  = 3'd2,
    CFG_SECOND_HIDDEN = 3'd3,
    CFG_OUTPUT_COUNT  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_PARAM   = 1'b0,
    CMD_FEATURE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BIAS,
    ST_MAC,
    ST_WAIT
  } st_e;

  typedef enum logic [1:0] {
    LAY_FIRST,
    LAY_SECOND,
    LAY_LAST
  } lay_e;

  typedef struct packed {
    logic valid;
    logic bias;
    logic last;
    logic leaky;
  } mac_ctl_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                    input logic [COUNT_W-1:0] lim);
    logic [COUNT_W-1:0] r;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mlp_leaky_relu_inference.sv =====
// Top level of the leaky-ReLU MLP inference block: command decode, config
// registers, layer sequencer, parameter and activation RAMs, output word.
// Depends on mlri_pkg, mlri_ram and mlri_mac.
//
// Usage: an input word is taken at a rising edge with start high and busy low.
// command 0 writes data_value into the parameter RAM at param_address (per
// layer: row-major weights, then biases, layers back to back from address 0).
// command 1 stores the next feature.
// The feature that completes input_count starts an inference; busy stays high
// until the last output neuron is done. One MAC serves every product. Each
// layer begins with a setup state; each neuron has a bias step, a MAC step
// for each input and a wait for the MAC result. Output words come one per
// last-layer neuron, each on out_value_o/out_index_o/out_last_o with
// out_strobe_o high for a single cycle; the final one appears in the same
// cycle that busy drops.
// The receiver cannot stall; words are never held. Config writes (cfg_we_i)
// take effect at once; the user must make them while idle, the block won't check.
// Reset returns the config to its defaults and clears the feature count; the
// RAMs are not cleared.
`default_nettype none

module mlp_leaky_relu_inference import mlri_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command_i,
  input  logic [ADDR_W-1:0]        param_address_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output logic                     out_strobe_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [OIDX_W-1:0]        out_index_o,
  output logic                     out_last_o
);

  st_e                  st_q, st_d;
  lay_e                 layer_q, layer_d;
  logic [COUNT_W-1:0]   n_in_q, n_in_d, n_out_q, n_out_d;
  logic [ADDR_W-1:0]    base_q, base_d, bias_base_q, bias_base_d, w_addr_q, w_addr_d;
  logic [BUF_AW-1:0]    i_q, i_d, o_q, o_d;
  logic [COUNT_W-1:0]   recv_q, recv_d, recv_inc;

  logic                 three_layer_q;
  logic [COUNT_W-1:0]   input_count_q, first_hidden_q, second_hidden_q;
  logic [OUTCNT_W-1:0]  output_count_q;
  logic [COUNT_W-1:0]   n0_c, n1_c, n2_c, nl_c;

  logic                 accept, feat_acc, par_acc, fire, i_last, o_last;
  logic [2*COUNT_W-1:0] layer_words;
  logic [ADDR_W-1:0]    pmem_raddr;
  logic [DATA_W-1:0]    pmem_rdata, fbuf_rdata, h1_rdata, h2_rdata;
  logic signed [DATA_W-1:0] src_data, mac_res;
  logic                 h1_we, h2_we, out_fire, mac_done;
  mac_ctl_t             mac_ctl;

  logic                     out_strobe_q, out_last_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [OIDX_W-1:0]        out_index_q;

  assign busy     = (st_q != ST_IDLE);
  assign accept   = start && !busy;
  assign feat_acc = accept && (command_i == CMD_FEATURE);
  assign par_acc  = accept && (command_i == CMD_PARAM);
  assign recv_inc = recv_q + COUNT_W'(1);
  assign fire     = feat_acc && (recv_inc >= n0_c);

  assign n0_c = clamp_count(input_count_q, COUNT_W'(MAX_INPUTS));
  assign n1_c = clamp_count(first_hidden_q, COUNT_W'(MAX_HIDDEN));
  assign n2_c = clamp_count(second_hidden_q, COUNT_W'(MAX_HIDDEN));
  assign nl_c = clamp_count({{(COUNT_W-OUTCNT_W){1'b0}}, output_count_q},
                            COUNT_W'(MAX_OUTPUTS));

  assign i_last      = (COUNT_W'(i_q) + COUNT_W'(1)) == n_in_q;
  assign o_last      = (COUNT_W'(o_q) + COUNT_W'(1)) == n_out_q;
  assign layer_words = n_in_q * n_out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_layer_q   <= 1'b1;
      input_count_q   <= COUNT_W'(64);
      first_hidden_q  <= COUNT_W'(64);
      second_hidden_q <= COUNT_W'(64);
      output_count_q  <= OUTCNT_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THREE_LAYER:   three_layer_q   <= cfg_data_i[0];
        CFG_INPUT_COUNT:   input_count_q   <= cfg_data_i[COUNT_W-1:0];
        CFG_FIRST_HIDDEN:  first_hidden_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_SECOND_HIDDEN: second_hidden_q <= cfg_data_i[COUNT_W-1:0];
        CFG_OUTPUT_COUNT:  output_count_q  <= cfg_data_i[OUTCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (fire) st_d = ST_SETUP;
      ST_SETUP: st_d = ST_BIAS;
      ST_BIAS:  st_d = ST_MAC;
      ST_MAC:   if (i_last) st_d = ST_WAIT;
      ST_WAIT: begin
        if (mac_done) begin
          if (!o_last) begin
            st_d = ST_BIAS;
          end else if (layer_q == LAY_LAST) begin
            st_d = ST_IDLE;
          end else begin
            st_d = ST_SETUP;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and counters
  always_comb begin
    layer_d     = layer_q;
    n_in_d      = n_in_q;
    n_out_d     = n_out_q;
    base_d      = base_q;
    bias_base_d = bias_base_q;
    w_addr_d    = w_addr_q;
    i_d         = i_q;
    o_d         = o_q;
    recv_d      = recv_q;
    pmem_raddr  = w_addr_q;
    mac_ctl     = '0;
    h1_we       = 1'b0;
    h2_we       = 1'b0;
    out_fire    = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (feat_acc) begin
          recv_d = fire ? '0 : recv_inc;
        end
        if (fire) begin
          layer_d = LAY_FIRST;
          n_in_d  = n0_c;
          n_out_d = n1_c;
          base_d  = '0;
        end
      end
      ST_SETUP: begin
        bias_base_d = base_q + ADDR_W'(layer_words);
        w_addr_d    = base_q;
        o_d         = '0;
      end
      ST_BIAS: begin
        pmem_raddr    = bias_base_q + ADDR_W'(o_q);
        mac_ctl.valid = 1'b1;
        mac_ctl.bias  = 1'b1;
        mac_ctl.leaky = (layer_q != LAY_LAST);
        i_d           = '0;
      end
      ST_MAC: begin
        pmem_raddr    = w_addr_q;
        mac_ctl.valid = 1'b1;
        mac_ctl.last  = i_last;
        mac_ctl.leaky = (layer_q != LAY_LAST);
        w_addr_d      = w_addr_q + ADDR_W'(1);
        i_d           = i_q + BUF_AW'(1);
      end
      ST_WAIT: begin
        if (mac_done) begin
          case (layer_q)
            LAY_FIRST:  h1_we    = 1'b1;
            LAY_SECOND: h2_we    = 1'b1;
            default:    out_fire = 1'b1;
          endcase
          if (o_last) begin
            base_d = bias_base_q + ADDR_W'(n_out_q);
            n_in_d = n_out_q;
            case (layer_q)
              LAY_FIRST: begin
                if (three_layer_q) begin
                  layer_d = LAY_SECOND;
                  n_out_d = n2_c;
                end else begin
                  layer_d = LAY_LAST;
                  n_out_d = nl_c;
                end
              end
              LAY_SECOND: begin
                layer_d = LAY_LAST;
                n_out_d = nl_c;
              end
              default: ;
            endcase
          end else begin
            o_d = o_q + BUF_AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      layer_q      <= LAY_FIRST;
      recv_q       <= '0;
      out_strobe_q <= 1'b0;
    end else begin
      st_q         <= st_d;
      layer_q      <= layer_d;
      recv_q       <= recv_d;
      out_strobe_q <= out_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    n_in_q      <= n_in_d;
    n_out_q     <= n_out_d;
    base_q      <= base_d;
    bias_base_q <= bias_base_d;
    w_addr_q    <= w_addr_d;
    i_q         <= i_d;
    o_q         <= o_d;
    if (out_fire) begin
      out_value_q <= mac_res;
      out_index_q <= o_q[OIDX_W-1:0];
      out_last_q  <= o_last;
    end
  end

  always_comb begin
    case (layer_q)
      LAY_FIRST:  src_data = fbuf_rdata;
      LAY_SECOND: src_data = h1_rdata;
      default:    src_data = three_layer_q ? h2_rdata : h1_rdata;
    endcase
  end

  mlri_ram #(.Depth(PARAM_DEPTH), .Width(DATA_W)) u_pmem (
    .clk_i   (clk_i),
    .we_i    (par_acc),
    .waddr_i (param_address_i),
    .wdata_i (data_value_i),
    .raddr_i (pmem_raddr),
    .rdata_o (pmem_rdata)
  );

  mlri_ram #(.Depth(MAX_INPUTS), .Width(DATA_W)) u_fbuf (
    .clk_i   (clk_i),
    .we_i    (feat_acc),
    .waddr_i (recv_q[BUF_AW-1:0]),
    .wdata_i (data_value_i),
    .raddr_i (i_q),
    .rdata_o (fbuf_rdata)
  );

  mlri_ram #(.Depth(MAX_HIDDEN), .Width(DATA_W)) u_h1buf (
    .clk_i   (clk_i),
    .we_i    (h1_we),
    .waddr_i (o_q),
    .wdata_i (mac_res),
    .raddr_i (i_q),
    .rdata_o (h1_rdata)
  );

  mlri_ram #(.Depth(MAX_HIDDEN), .Width(DATA_W)) u_h2buf (
    .clk_i   (clk_i),
    .we_i    (h2_we),
    .waddr_i (o_q),
    .wdata_i (mac_res),
    .raddr_i (i_q),
    .rdata_o (h2_rdata)
  );

  mlri_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .weight_i  (pmem_rdata),
    .operand_i (src_data),
    .done_o    (mac_done),
    .result_o  (mac_res)
  );

  assign out_strobe_o = out_strobe_q;
  assign out_value_o  = out_value_q;
  assign out_index_o  = out_index_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/mlri_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
`default_nettype none

module mlri_ram #(
  parameter int Depth = 64,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/mlri_mac.sv =====
// Shared multiply-accumulate unit with Q4.12 rounding, leaky ReLU and
// saturation in a short post pipeline. Depends on mlri_pkg.
`default_nettype none

module mlri_mac import mlri_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [DATA_W-1:0] weight_i,
  input  logic signed [DATA_W-1:0] operand_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] result_o
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int Y_W    = ACC_W - FRAC_W;
  localparam int COEF_W = FRAC_W + 2;
  localparam int M_W    = Y_W + COEF_W;
  localparam int Z_W    = M_W - FRAC_W;

  localparam logic signed [COEF_W-1:0] COEF_SLOPE = COEF_W'(SLOPE_Q);
  localparam logic signed [COEF_W-1:0] COEF_UNIT  = COEF_W'(ONE_Q);
  localparam logic signed [Z_W-1:0]    ZMAX       = Z_W'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [Z_W-1:0]    ZMIN       = ~ZMAX;

  mac_ctl_t                   ctl_a_q, ctl_b_q;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [ACC_W-1:0]    prod_ext, acc_d, acc_q, rnd_sum;
  logic                       fin_q, leaky_c_q;
  logic signed [Y_W-1:0]      y_q;
  logic                       p1_q, leaky_p1_q;
  logic signed [COEF_W-1:0]   coef;
  logic signed [M_W-1:0]      m_d, m_q, z_sum;
  logic                       p2_q;
  logic signed [Z_W-1:0]      z;
  logic signed [DATA_W-1:0]   res_d, res_q;
  logic                       done_q;

  always_comb begin
    if (ctl_a_q.bias) begin
      prod_d = {{(PROD_W-DATA_W-FRAC_W){weight_i[DATA_W-1]}}, weight_i, {FRAC_W{1'b0}}};
    end else begin
      prod_d = weight_i * operand_i;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = ctl_b_q.bias ? prod_ext : acc_q + prod_ext;
  assign rnd_sum  = acc_q + ACC_W'(RND_HALF);
  assign coef     = (leaky_p1_q && y_q[Y_W-1]) ? COEF_SLOPE : COEF_UNIT;
  assign m_d      = y_q * coef;
  assign z_sum    = m_q + M_W'(RND_HALF);
  assign z        = z_sum[M_W-1:FRAC_W];

  always_comb begin
    if (z > ZMAX) begin
      res_d = ZMAX[DATA_W-1:0];
    end else if (z < ZMIN) begin
      res_d = ZMIN[DATA_W-1:0];
    end else begin
      res_d = z[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      fin_q   <= 1'b0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      fin_q   <= ctl_b_q.valid && ctl_b_q.last;
      p1_q    <= fin_q;
      p2_q    <= p1_q;
      done_q  <= p2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_a_q.valid) begin
      prod_q <= prod_d;
    end
    if (ctl_b_q.valid) begin
      acc_q     <= acc_d;
      leaky_c_q <= ctl_b_q.leaky;
    end
    if (fin_q) begin
      y_q        <= rnd_sum[ACC_W-1:FRAC_W];
      leaky_p1_q <= leaky_c_q;
    end
    if (p1_q) begin
      m_q <= m_d;
    end
    if (p2_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== hdl/mlri_checker.sv =====
// Port-level checks on the MLP inference block, bound to the top level.
// Depends on mlri_pkg and mlp_leaky_relu_inference.
`default_nettype none

module mlri_checker import mlri_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              command_i,
  input logic              out_strobe_o,
  input logic              out_last_o
);

  // words are at least a neuron apart; checked as no words on consecutive cycles
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |=> !out_strobe_o)
    else $error("output words on consecutive cycles");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !out_last_o) |-> busy)
    else $error("non-final word while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && out_last_o) |-> !busy)
    else $error("final word while still busy");

  a_param_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_PARAM)) |=> !busy)
    else $error("parameter write started an inference");

endmodule

bind mlp_leaky_relu_inference mlri_checker u_mlri_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .command_i    (command_i),
  .out_strobe_o (out_strobe_o),
  .out_last_o   (out_last_o)
);

`default_nettype wire
